// ===== hw/rtl/ssl_pkg.sv =====
// ----------------------------------------------------------------------------
// ssl_pkg
// shared types and constants of the spring strain limiter
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int PosW      = 32;
  localparam int RateW     = 16;
  localparam int RateFrac  = 12;
  localparam int RatioBits = 30;
  localparam int LimitW    = PosW + RateW - RateFrac;  // 36
  localparam int RatioW    = RatioBits + 1;            // ratio <= 2^30
  localparam int DivSteps  = RatioW;                   // quotient bits

  localparam logic [RateW-1:0] RateReset = 16'd4424;

  typedef enum logic [0:0] {
    REG_MAX_STRETCH_RATE = 1'b0,
    REG_LIMIT_ENABLE     = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [PosW-1:0] first_x;
    logic signed [PosW-1:0] first_y;
    logic signed [PosW-1:0] first_z;
    logic signed [PosW-1:0] second_x;
    logic signed [PosW-1:0] second_y;
    logic signed [PosW-1:0] second_z;
    logic                   first_movable;
    logic                   second_movable;
    logic [PosW-1:0]        rest_length;
    logic [PosW-1:0]        current_length;
  } spring_in_t;

  typedef struct packed {
    logic signed [PosW-1:0] new_first_x;
    logic signed [PosW-1:0] new_first_y;
    logic signed [PosW-1:0] new_first_z;
    logic signed [PosW-1:0] new_second_x;
    logic signed [PosW-1:0] new_second_y;
    logic signed [PosW-1:0] new_second_z;
    logic                   was_overstretched;
  } spring_out_t;

  typedef struct packed {
    logic [1:0] index;
    logic [RateW-1:0] data;
  } cfg_wr_t;

endpackage

// ===== hw/rtl/ssl_if.sv =====
// ----------------------------------------------------------------------------
// ssl_if
// valid/ready channels of the spring strain limiter
// ----------------------------------------------------------------------------
interface ssl_in_if;
  import ssl_pkg::*;
  logic       valid;
  logic       ready;
  spring_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssl_out_if;
  import ssl_pkg::*;
  logic        valid;
  logic        ready;
  spring_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssl_cfg_if;
  import ssl_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/spring_strain_limiter.sv =====
// ----------------------------------------------------------------------------
// spring_strain_limiter
// strain limiting of one cloth spring per transaction
// ----------------------------------------------------------------------------
// throughput: one spring per cycle while the output is not stalled; the ratio divider is a 31-stage
//   restoring pipeline, one quotient bit per stage
// a stall at the output freezes the whole pipeline in place
// rst clears valid bits and resets max_stretch_rate to 1.08, limit_enable to 1
module spring_strain_limiter
  import ssl_pkg::*;
(
  input logic clk,
  input logic rst,
  ssl_in_if.sink    in_ch,
  ssl_out_if.source out_ch,
  ssl_cfg_if.sink   cfg
);

  localparam int NDiv = DivSteps;
  // remainder width: divisor up to 32 bits, remainder < divisor, shift one
  localparam int RemW = PosW + 1;

  // configuration registers
  logic [RateW-1:0] max_stretch_rate;
  logic             limit_enable;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_stretch_rate <= RateReset;
      limit_enable     <= 1'b1;
    end else if (cfg.valid) begin
      if (cfg.data.index == 2'(REG_MAX_STRETCH_RATE))
        max_stretch_rate <= cfg.data.data;
      else if (cfg.data.index == 2'(REG_LIMIT_ENABLE))
        limit_enable <= cfg.data.data[0];
    end
  end

  // whole pipeline advances together; a free output slot lets it move
  logic advance;
  assign advance = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;

  // ---------------------------------------------------------------- stage 1
  // limit = rest * rate >> 12; the overstretch test follows in stage 2
  logic       s1_valid;
  spring_in_t s1_d;
  logic [LimitW-1:0] s1_limit;
  logic       s1_en;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (advance) s1_valid <= in_ch.valid;
    if (advance) begin
      s1_d     <= in_ch.data;
      s1_limit <= LimitW'((48'(in_ch.data.rest_length) * 48'(max_stretch_rate)) >> RateFrac);
      s1_en    <= limit_enable;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // overshoot and the move decision
  logic       s2_valid;
  spring_in_t s2_d;
  logic       s2_over;
  logic       s2_apply;
  logic [PosW-1:0] s2_num;
  logic       over_c;

  assign over_c = s1_en && ({{(LimitW-PosW){1'b0}}, s1_d.current_length} > s1_limit);

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (advance) s2_valid <= s1_valid;
    if (advance) begin
      s2_d     <= s1_d;
      s2_over  <= over_c;
      s2_apply <= over_c && (s1_d.first_movable || s1_d.second_movable);
      // overshoot fits 32 bits when over (cur > limit >= 0)
      s2_num   <= over_c ? (s1_d.current_length - PosW'(s1_limit)) : '0;
    end
  end

  // ---------------------------------------------------------------- divider
  // ratio = (num << 30) / cur, num <= cur; dividend bits are num then zeros,
  // so each later stage shifts in a zero; every stage produces one quotient bit, MSB first
  logic       dv_valid [NDiv+1];
  spring_in_t dv_d     [NDiv+1];
  logic       dv_over  [NDiv+1];
  logic       dv_apply [NDiv+1];
  logic [RemW-1:0]   dv_rem [NDiv+1];
  logic [RatioW-1:0] dv_q   [NDiv+1];

  assign dv_valid[0] = s2_valid;
  assign dv_d[0]     = s2_d;
  assign dv_over[0]  = s2_over;
  assign dv_apply[0] = s2_apply;
  // first quotient bit is the 2^30 weight: compare num itself against cur
  assign dv_rem[0]   = {1'b0, s2_num};
  assign dv_q[0]     = '0;

  for (genvar k = 0; k < NDiv; k++) begin : g_div
    logic [RemW-1:0] trial;
    logic [RemW-1:0] cand;
    logic            bit_q;
    // stage 0 compares num directly; later stages shift the remainder first
    assign cand  = (k == 0) ? dv_rem[k] : {dv_rem[k][RemW-2:0], 1'b0};
    assign bit_q = cand >= {1'b0, dv_d[k].current_length};
    assign trial = bit_q ? (cand - {1'b0, dv_d[k].current_length}) : cand;

    always_ff @(posedge clk) begin
      if (rst) dv_valid[k+1] <= 1'b0;
      else if (advance) dv_valid[k+1] <= dv_valid[k];
      if (advance) begin
        dv_d[k+1]     <= dv_d[k];
        dv_over[k+1]  <= dv_over[k];
        dv_apply[k+1] <= dv_apply[k];
        dv_rem[k+1]   <= trial;
        dv_q[k+1]     <= {dv_q[k][RatioW-2:0], bit_q};
      end
    end
  end

  // ---------------------------------------------------------------- multiply
  // |d| * ratio per axis, 33 x 31 bits
  localparam int DW = PosW + 1;
  localparam int ProdW = DW + RatioW;

  spring_in_t md;
  logic [RatioW-1:0] ratio;
  assign md    = dv_d[NDiv];
  assign ratio = dv_q[NDiv];

  logic signed [DW-1:0] dif [3];
  assign dif[0] = DW'(md.second_x) - DW'(md.first_x);
  assign dif[1] = DW'(md.second_y) - DW'(md.first_y);
  assign dif[2] = DW'(md.second_z) - DW'(md.first_z);

  logic       m_valid;
  spring_in_t m_d;
  logic       m_over;
  logic       m_apply;
  logic [ProdW-1:0] m_prod [3];
  logic [2:0]       m_neg;

  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else if (advance) m_valid <= dv_valid[NDiv];
    if (advance) begin
      m_d     <= md;
      m_over  <= dv_over[NDiv];
      m_apply <= dv_apply[NDiv];
      for (int a = 0; a < 3; a++) begin
        m_neg[a]  <= dif[a][DW-1];
        m_prod[a] <= ProdW'(dif[a][DW-1] ? -dif[a] : dif[a]) * ProdW'(ratio);
      end
    end
  end

  // ---------------------------------------------------------------- apply
  logic       a_valid;
  spring_out_t a_res;
  logic both;
  logic signed [PosW-1:0] corr [3];
  logic signed [PosW-1:0] p1 [3];
  logic signed [PosW-1:0] p2 [3];
  assign both = m_d.first_movable && m_d.second_movable;
  assign p1[0] = m_d.first_x;  assign p1[1] = m_d.first_y;  assign p1[2] = m_d.first_z;
  assign p2[0] = m_d.second_x; assign p2[1] = m_d.second_y; assign p2[2] = m_d.second_z;

  logic signed [PosW-1:0] n1 [3];
  logic signed [PosW-1:0] n2 [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [ProdW-1:0] mag;
      if (both)
        mag = (m_prod[a] + (ProdW'(1) << RatioBits)) >> (RatioBits + 1);
      else
        mag = (m_prod[a] + (ProdW'(1) << (RatioBits - 1))) >> RatioBits;
      corr[a] = m_neg[a] ? -PosW'(mag) : PosW'(mag);
      n1[a] = p1[a];
      n2[a] = p2[a];
      if (m_apply) begin
        if (m_d.first_movable)  n1[a] = p1[a] + corr[a];
        if (m_d.second_movable) n2[a] = p2[a] - corr[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (advance) a_valid <= m_valid;
    if (advance) begin
      a_res.new_first_x  <= n1[0];
      a_res.new_first_y  <= n1[1];
      a_res.new_first_z  <= n1[2];
      a_res.new_second_x <= n2[0];
      a_res.new_second_y <= n2[1];
      a_res.new_second_z <= n2[2];
      a_res.was_overstretched <= m_over;
    end
  end

  assign out_ch.valid = a_valid;
  assign out_ch.data  = a_res;

endmodule

// ===== test/ssl_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssl_checker
// predicts spring corrections from observed transactions and compares results
// ----------------------------------------------------------------------------
module ssl_checker
  import ssl_pkg::*;
(
  input logic clk,
  input logic rst,
  ssl_in_if.sink  in_mon,
  ssl_out_if.sink out_mon,
  ssl_cfg_if.sink cfg_mon,
  output int      fail_count,
  output int      pending,
  output int      result_count,
  output int      over_count
);

  logic [RateW-1:0] rate_q;
  logic             enable_q;
  spring_out_t      corrections_due[$];

  // rounded signed scaling, magnitude (|d|*ratio + half) >> sh
  function automatic longint scale_diff(longint d, longint unsigned ratio, int sh);
    longint unsigned mag;
    longint unsigned r;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    r = (mag * ratio + (64'd1 << (sh - 1))) >> sh;
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic spring_out_t limit_spring(spring_in_t s);
    spring_out_t     o;
    longint          p1[3];
    longint          p2[3];
    longint          d;
    longint          c;
    longint unsigned lim;
    longint unsigned cur;
    longint unsigned ratio;
    logic            over;
    p1[0] = s.first_x;  p1[1] = s.first_y;  p1[2] = s.first_z;
    p2[0] = s.second_x; p2[1] = s.second_y; p2[2] = s.second_z;
    cur = 64'(s.current_length);
    lim = (64'(s.rest_length) * 64'(rate_q)) >> RateFrac;
    over = enable_q && (cur > lim);
    if (over && (s.first_movable || s.second_movable)) begin
      ratio = ((cur - lim) << RatioBits) / cur;
      for (int i = 0; i < 3; i++) begin
        d = p2[i] - p1[i];
        if (s.first_movable && s.second_movable) begin
          c = scale_diff(d, ratio, RatioBits + 1);
          p1[i] += c;
          p2[i] -= c;
        end else begin
          c = scale_diff(d, ratio, RatioBits);
          if (s.first_movable) p1[i] += c;
          else p2[i] -= c;
        end
      end
    end
    o.new_first_x  = p1[0][31:0]; o.new_first_y  = p1[1][31:0];
    o.new_first_z  = p1[2][31:0]; o.new_second_x = p2[0][31:0];
    o.new_second_y = p2[1][31:0]; o.new_second_z = p2[2][31:0];
    o.was_overstretched = over;
    return o;
  endfunction

  task automatic check_field(string name, longint expv, longint actv);
    if (expv !== actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  assign pending = corrections_due.size();

  always @(posedge clk) begin
    spring_out_t e;
    spring_out_t a;
    if (rst) begin
      rate_q   <= RateReset;
      enable_q <= 1'b1;
      corrections_due.delete();
      fail_count   = 0;
      result_count = 0;
      over_count   = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        a = out_mon.data;
        result_count++;
        if (corrections_due.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count++;
        end else begin
          e = corrections_due.pop_front();
          if (e.was_overstretched) over_count++;
          check_field("new_first_x", e.new_first_x, a.new_first_x);
          check_field("new_first_y", e.new_first_y, a.new_first_y);
          check_field("new_first_z", e.new_first_z, a.new_first_z);
          check_field("new_second_x", e.new_second_x, a.new_second_x);
          check_field("new_second_y", e.new_second_y, a.new_second_y);
          check_field("new_second_z", e.new_second_z, a.new_second_z);
          check_field("was_overstretched", e.was_overstretched, a.was_overstretched);
        end
      end
      if (in_mon.valid && in_mon.ready)
        corrections_due.insert(corrections_due.size(), limit_spring(in_mon.data));
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.data.index == 2'(REG_MAX_STRETCH_RATE)) rate_q <= cfg_mon.data.data;
        else if (cfg_mon.data.index == 2'(REG_LIMIT_ENABLE)) enable_q <= cfg_mon.data.data[0];
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives springs and register writes into the strain limiter, random stalls
// ----------------------------------------------------------------------------
module tb_top;
  import ssl_pkg::*;

  localparam int Latency = 35;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   result_count;
  int   over_count;
  int   sent;

  // idling knobs, changed per phase
  bit   quiet = 1'b0;
  bit   long_hold = 1'b0;

  ssl_in_if  in_ch ();
  ssl_out_if out_ch ();
  ssl_cfg_if cfg ();

  spring_strain_limiter uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg    (cfg.sink)
  );

  ssl_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_mon       (in_ch.sink),
    .out_mon      (out_ch.sink),
    .cfg_mon      (cfg.sink),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .over_count   (over_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well past the slowest correct run
  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        for (int i = 0; i < 300; i++) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // offer one spring, hold until the transaction happens
  task automatic send_spring(spring_in_t s);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // register write while idle
  task automatic write_reg(reg_index_t idx, logic [RateW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.data.index <= 2'(idx);
    cfg.data.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  // mostly springs near or past their limit so correction paths dominate
  function automatic spring_in_t rand_spring();
    spring_in_t s;
    logic [31:0] r;
    s.first_x = rand_pos();  s.first_y = rand_pos();  s.first_z = rand_pos();
    s.second_x = rand_pos(); s.second_y = rand_pos(); s.second_z = rand_pos();
    s.first_movable  = 1'($urandom_range(0, 1));
    s.second_movable = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: begin
        s.rest_length = $urandom;
        s.current_length = $urandom;
      end
      1: begin
        s.rest_length = $urandom_range(0, 3);
        s.current_length = $urandom_range(0, 8);
      end
      default: begin
        r = $urandom >> $urandom_range(0, 31);
        s.rest_length = r;
        s.current_length = r + (r >> $urandom_range(0, 6)) + $urandom_range(0, 3) - 1;
      end
    endcase
    return s;
  endfunction

  function automatic spring_in_t mk(logic [31:0] v1, logic [31:0] v2, bit m1, bit m2,
                                     logic [31:0] rest, logic [31:0] cur);
    spring_in_t s;
    s.first_x = v1;  s.first_y = ~v1; s.first_z = 32'd0;
    s.second_x = v2; s.second_y = ~v2; s.second_z = 32'hffff_0000;
    s.first_movable = m1; s.second_movable = m2;
    s.rest_length = rest; s.current_length = cur;
    return s;
  endfunction

  initial begin
    logic [RateW-1:0] rates[6];
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg.valid   = 1'b0;
    cfg.data    = '0;
    sent = 0;
    rates = '{16'd0, 16'd4096, 16'd4424, 16'd8192, 16'hffff, 16'd3000};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, all movable combos, boundaries, zero length
    send_spring(mk(32'h8000_0000, 32'h7fff_ffff, 1, 1, 32'd65536, 32'hffff_ffff));
    send_spring(mk(32'h7fff_ffff, 32'h8000_0000, 1, 0, 32'd65536, 32'hffff_ffff));
    send_spring(mk(32'h8000_0000, 32'h7fff_ffff, 0, 1, 32'd65536, 32'd200000));
    send_spring(mk(32'd100, 32'd5000, 0, 0, 32'd65536, 32'd200000));
    send_spring(mk(32'd100, 32'd5000, 1, 1, 32'd4096, 32'd4424));  // exactly at limit
    send_spring(mk(32'd100, 32'd5000, 1, 1, 32'd4096, 32'd4425));  // just over
    send_spring(mk(32'd1, 32'hffff_ffff, 1, 1, 32'd0, 32'd0));     // zero length
    send_spring(mk(32'd7, 32'd3, 1, 1, 32'd0, 32'd1));
    send_spring(mk(32'd0, 32'd0, 1, 0, 32'hffff_ffff, 32'hffff_ffff));
    send_spring(mk(32'h1234_5678, 32'hfedc_ba98, 1, 1, 32'd10, 32'd99999)); // length mismatch
    drain();
    write_reg(REG_MAX_STRETCH_RATE, 16'hffff);  // limit beyond 32 bits
    send_spring(mk(32'h8000_0000, 32'h7fff_ffff, 1, 1, 32'hffff_ffff, 32'hffff_ffff));
    send_spring(mk(32'd0, 32'd9, 1, 1, 32'h0001_0000, 32'hffff_ffff));
    drain();
    write_reg(REG_MAX_STRETCH_RATE, 16'd0);
    write_reg(REG_LIMIT_ENABLE, 16'd0);
    send_spring(mk(32'd5, 32'd900, 1, 1, 32'd1, 32'hffff_ffff));
    drain();
    write_reg(REG_LIMIT_ENABLE, 16'd1);
    send_spring(mk(32'd5, 32'd900, 1, 1, 32'd1, 32'd1));
    send_spring(mk(32'h8000_0000, 32'h7fff_ffff, 1, 0, 32'hffff_ffff, 32'hffff_ffff));

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(REG_MAX_STRETCH_RATE, rates[ph]);
      write_reg(REG_LIMIT_ENABLE, (ph == 4) ? 16'd0 : 16'd1);
      if (ph == 2) long_hold = 1'b1;
      if (ph == 5) quiet = 1'b1;
      for (int i = 0; i < 225; i++) send_spring(rand_spring());
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
    $display("run: %0d springs sent, %0d results checked, %0d over the limit",
             sent, result_count, over_count);
    $display("run: six rate settings incl. 0 and max, limiting on and off, long output hold");
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
